[rtl/core/scpu_pkg.sv]
// Package for the small 16-bit processor core.
// Holds opcodes, widths and the result record; used by the top level, sequencer and divider.
package scpu_pkg;

  localparam int unsigned MemBytesDefault = 256;
  localparam int unsigned OpW = 5;

  localparam logic [OpW-1:0] OP_HLT  = 5'd0;
  localparam logic [OpW-1:0] OP_NOP  = 5'd1;
  localparam logic [OpW-1:0] OP_LDR  = 5'd2;
  localparam logic [OpW-1:0] OP_STR  = 5'd3;
  localparam logic [OpW-1:0] OP_ADD  = 5'd4;
  localparam logic [OpW-1:0] OP_SUB  = 5'd5;
  localparam logic [OpW-1:0] OP_MUL  = 5'd6;
  localparam logic [OpW-1:0] OP_DIV  = 5'd7;
  localparam logic [OpW-1:0] OP_CMP  = 5'd8;
  localparam logic [OpW-1:0] OP_MOVR = 5'd9;
  localparam logic [OpW-1:0] OP_AND  = 5'd10;
  localparam logic [OpW-1:0] OP_OR   = 5'd11;
  localparam logic [OpW-1:0] OP_XOR  = 5'd12;
  localparam logic [OpW-1:0] OP_NOT  = 5'd13;
  localparam logic [OpW-1:0] OP_JE   = 5'd14;
  localparam logic [OpW-1:0] OP_JNE  = 5'd15;
  localparam logic [OpW-1:0] OP_JL   = 5'd16;
  localparam logic [OpW-1:0] OP_JLE  = 5'd17;
  localparam logic [OpW-1:0] OP_JG   = 5'd18;
  localparam logic [OpW-1:0] OP_JGE  = 5'd19;
  localparam logic [OpW-1:0] OP_JMP  = 5'd20;
  localparam logic [OpW-1:0] OP_LD   = 5'd21;
  localparam logic [OpW-1:0] OP_ST   = 5'd22;
  localparam logic [OpW-1:0] OP_MOVI = 5'd23;
  localparam logic [OpW-1:0] OP_ADDI = 5'd24;
  localparam logic [OpW-1:0] OP_SUBI = 5'd25;
  localparam logic [OpW-1:0] OP_MULI = 5'd26;
  localparam logic [OpW-1:0] OP_DIVI = 5'd27;
  localparam logic [OpW-1:0] OP_LSH  = 5'd28;
  localparam logic [OpW-1:0] OP_RSH  = 5'd29;
  // First of the undefined opcodes, which run as 3-byte no-ops.
  localparam logic [OpW-1:0] OP_BAD  = 5'd30;

  // One result item as it leaves the core.
  typedef struct packed {
    logic       bad_opcode;
    logic       halt_seen;
    logic       flag_greater;
    logic       flag_less;
    logic       flag_equal;
    logic       mem_written;
    logic       reg_written;
    logic [15:0] dest_value;
    logic [1:0]  dest_index;
    logic [4:0]  opcode;
    logic [15:0] pc_after;
  } result_t;

  // Divider handshake between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/small_cpu_fetch_decode_execute_core.sv]
// Top level of the small 16-bit processor core with stream ports.
// Depends on scpu_pkg and scpu_seq (which holds scpu_div).
//
//  channel | dir | tdata fields (low bit first)     | tuser
//  in_     | in  | load_addr[7:0], load_data[15:8]   | func
//  out_    | out | pc_after..bad_opcode, 48 bits     | none
//
// From accept to out_tvalid a load item passes S_DONE; a step item passes S_F0, then S_F1
// and S_F2 as its instruction bytes need, then S_EXEC and S_DONE; a word load adds S_RDHI
// and S_RDLO, a word store S_WRLO, a nonzero divide S_DIV (one-bit-per-cycle divider).
// With out_tready high, taking the result clears busy_r so the next item can be accepted.
// Reset clears registers, flags and program counter; memory is left as is.
// One item is in work at a time; the result register holds while out_tready is low.
module small_cpu_fetch_decode_execute_core #(
  parameter int unsigned MEM_BYTES = scpu_pkg::MemBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // load_addr[7:0], load_data[15:8]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // pc_after, opcode, dest_index, dest_value, reg_written,
                                  // mem_written, flag_equal, flag_less, flag_greater,
                                  // halt_seen, bad_opcode, zero fill
);

  logic              busy_r, busy_nxt;
  logic              ovalid_r;
  logic [47:0]       odata_r;
  logic              done;
  logic              start;
  scpu_pkg::result_t res;

  assign in_tready = !busy_r;
  assign start     = in_tvalid && in_tready;

  scpu_seq #(.MEM_BYTES(MEM_BYTES)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .func     (in_tuser),
    .load_addr(in_tdata[7:0]),
    .load_data(in_tdata[15:8]),
    .done     (done),
    .res      (res)
  );

  // Busy from accept until the result is taken.
  always_comb begin
    busy_nxt = busy_r;
    if (start) busy_nxt = 1'b1;
    if (ovalid_r && out_tready) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (done) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
    if (done) begin
      odata_r <= {2'b00, res.bad_opcode, res.halt_seen, res.flag_greater, res.flag_less,
                  res.flag_equal, res.mem_written, res.reg_written, res.dest_value,
                  res.dest_index, res.opcode, res.pc_after};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

[rtl/core/scpu_div.sv]
// Iterative 16-bit unsigned divider, one quotient bit per cycle.
// Depends on scpu_pkg for its request and response records.
module scpu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  scpu_pkg::div_req_t req,
  output scpu_pkg::div_rsp_t rsp
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] shifted;

  // One restoring step per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[15]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_nxt = trial[15:0];
      end else begin
        rem_nxt = shifted[15:0];
      end
      quo_nxt = {quo_r[14:0], ~trial[16]};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[rtl/core/scpu_seq.sv]
// Fetch, decode and execute sequencer with the byte memory and register file.
// Depends on scpu_pkg and on scpu_div for divide instructions.
module scpu_seq #(
  parameter int unsigned MEM_BYTES = scpu_pkg::MemBytesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               func,
  input  logic [7:0]         load_addr,
  input  logic [7:0]         load_data,
  output logic               done,
  output scpu_pkg::result_t  res
);

  localparam int unsigned AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  // A power-of-two memory is indexed by a mask, any other size by a reciprocal
  // multiplication that is exact for all 16-bit addresses when the size is above 16.
  localparam bit MemPow2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
  localparam logic [27:0] MemRecip =
    28'(((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES));

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_F0    = 10'b0000000010,
    S_F1    = 10'b0000000100,
    S_F2    = 10'b0000001000,
    S_EXEC  = 10'b0000010000,
    S_RDHI  = 10'b0000100000,
    S_RDLO  = 10'b0001000000,
    S_WRLO  = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Byte memory, one port, registered read.
  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] maddr;
  logic          mwe;
  logic [7:0]    mwdata;

  logic [15:0] regs_r [4];
  logic [15:0] pc_r, pc_nxt;
  logic        feq_r, flt_r, fgt_r;
  logic [7:0]  b0_r, b1_r, b2_r;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  word_r;
  logic        wreg_r, wmem_r;
  logic        wreg_set;
  logic [15:0] wval;
  logic        done_r;
  logic        load_r;

  scpu_pkg::div_req_t dreq;
  scpu_pkg::div_rsp_t drsp;

  logic [4:0]  op;
  logic [1:0]  rx, ry;
  logic [15:0] opnd, a, b;
  logic [31:0] prod;
  logic        take;
  logic [15:0] alu;
  logic        alu_w;

  function automatic logic [AW-1:0] widx(input logic [15:0] x);
    logic [43:0] scaled;
    logic [15:0] quo;
    logic [15:0] back;
    logic [15:0] m;
    scaled = {28'd0, x} * {16'd0, MemRecip};
    quo    = {4'd0, scaled[43:32]};
    back   = quo * 16'(MEM_BYTES);
    m      = MemPow2 ? x : (x - back);
    return m[AW-1:0];
  endfunction

  assign op   = b0_r[7:3];
  assign rx   = b0_r[2:1];
  assign ry   = {b0_r[0], b1_r[7]};
  assign opnd = {b1_r, b2_r};
  assign a    = regs_r[rx];
  assign b    = (op >= scpu_pkg::OP_MOVI) ? opnd : regs_r[ry];
  assign prod = a * b;

  scpu_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // Combinational ALU results and jump decision.
  always_comb begin
    alu   = '0;
    alu_w = 1'b0;
    take  = 1'b0;
    unique case (op)
      scpu_pkg::OP_ADD, scpu_pkg::OP_ADDI: begin alu = a + b; alu_w = 1'b1; end
      scpu_pkg::OP_SUB, scpu_pkg::OP_SUBI: begin alu = a - b; alu_w = 1'b1; end
      scpu_pkg::OP_MUL, scpu_pkg::OP_MULI: begin alu = prod[15:0]; alu_w = 1'b1; end
      scpu_pkg::OP_MOVR, scpu_pkg::OP_MOVI: begin alu = b; alu_w = 1'b1; end
      scpu_pkg::OP_AND: begin alu = a & b; alu_w = 1'b1; end
      scpu_pkg::OP_OR:  begin alu = a | b; alu_w = 1'b1; end
      scpu_pkg::OP_XOR: begin alu = a ^ b; alu_w = 1'b1; end
      scpu_pkg::OP_NOT: begin alu = ~a; alu_w = 1'b1; end
      scpu_pkg::OP_LSH: begin alu = (b >= 16'd16) ? 16'd0 : (a << b[3:0]); alu_w = 1'b1; end
      scpu_pkg::OP_RSH: begin alu = (b >= 16'd16) ? 16'd0 : (a >> b[3:0]); alu_w = 1'b1; end
      scpu_pkg::OP_JE:  take = feq_r;
      scpu_pkg::OP_JNE: take = !feq_r;
      scpu_pkg::OP_JL:  take = flt_r;
      scpu_pkg::OP_JLE: take = flt_r | feq_r;
      scpu_pkg::OP_JG:  take = fgt_r;
      scpu_pkg::OP_JGE: take = fgt_r | feq_r;
      scpu_pkg::OP_JMP: take = 1'b1;
      default: ;
    endcase
  end

  // Sequencer: memory address and write, program counter, divider request, register write and next state.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    addr_nxt  = addr_r;
    maddr     = widx(pc_r);
    mwe       = 1'b0;
    mwdata    = a[15:8];
    dreq      = '0;
    wreg_set  = 1'b0;
    wval      = alu;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!func) begin
            maddr     = widx({8'd0, load_addr});
            mwe       = 1'b1;
            mwdata    = load_data;
            state_nxt = S_DONE;
          end else begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = S_F0;
          end
        end
      end
      S_F0: begin
        // rdata holds byte 0; request byte 1 when needed.
        if (rdata_r[7:3] >= scpu_pkg::OP_LDR) begin
          pc_nxt    = pc_r + 16'd1;
          state_nxt = S_F1;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_F1: begin
        if (b0_r[7:3] >= scpu_pkg::OP_JE) begin
          pc_nxt    = pc_r + 16'd1;
          state_nxt = S_F2;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_F2: state_nxt = S_EXEC;
      S_EXEC: begin
        if (take) pc_nxt = opnd;
        state_nxt = S_DONE;
        unique case (op)
          scpu_pkg::OP_LDR, scpu_pkg::OP_LD: begin
            addr_nxt  = (op == scpu_pkg::OP_LDR) ? regs_r[ry] : opnd;
            maddr     = widx(addr_nxt);
            state_nxt = S_RDHI;
          end
          scpu_pkg::OP_STR, scpu_pkg::OP_ST: begin
            addr_nxt  = (op == scpu_pkg::OP_STR) ? regs_r[ry] : opnd;
            maddr     = widx(addr_nxt);
            mwe       = 1'b1;
            state_nxt = S_WRLO;
          end
          scpu_pkg::OP_DIV, scpu_pkg::OP_DIVI: begin
            if (b != 16'd0) begin
              dreq.start    = 1'b1;
              dreq.dividend = a;
              dreq.divisor  = b;
              state_nxt     = S_DIV;
            end
          end
          default: wreg_set = alu_w;
        endcase
      end
      S_RDHI: begin
        maddr     = widx(addr_r + 16'd1);
        state_nxt = S_RDLO;
      end
      S_RDLO: state_nxt = S_DONE;
      S_WRLO: begin
        maddr     = widx(addr_r + 16'd1);
        mwe       = 1'b1;
        mwdata    = a[7:0];
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (drsp.done) begin
          wreg_set  = 1'b1;
          wval      = drsp.quotient;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_RDLO) begin
      wreg_set = 1'b1;
      wval     = {word_r, rdata_r};
    end
  end

  // Memory array, registered read.
  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    rdata_r <= mem[maddr];
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      feq_r   <= 1'b0;
      flt_r   <= 1'b0;
      fgt_r   <= 1'b0;
      for (int i = 0; i < 4; i++) regs_r[i] <= '0;
      wreg_r  <= 1'b0;
      wmem_r  <= 1'b0;
      done_r  <= 1'b0;
      load_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      done_r  <= (state_r == S_DONE);
      if (state_r == S_IDLE && start) begin
        load_r <= !func;
        wreg_r <= 1'b0;
        wmem_r <= !func;
        b0_r   <= '0;
        b1_r   <= '0;
        b2_r   <= '0;
      end
      if (state_r == S_EXEC) begin
        if (op == scpu_pkg::OP_CMP) begin
          feq_r <= (a == b);
          flt_r <= (a < b);
          fgt_r <= (a > b);
        end
        if (op == scpu_pkg::OP_STR || op == scpu_pkg::OP_ST) wmem_r <= 1'b1;
      end
      if (wreg_set) begin
        regs_r[rx] <= wval;
        wreg_r     <= 1'b1;
      end
    end
    if (state_r == S_F0) b0_r <= rdata_r;
    if (state_r == S_F1) b1_r <= rdata_r;
    if (state_r == S_F2) b2_r <= rdata_r;
    if (state_r == S_RDHI || state_r == S_EXEC) addr_r <= addr_nxt;
    // The high byte of a word read arrives in S_RDHI, ahead of the low byte in S_RDLO.
    if (state_r == S_RDHI) word_r <= rdata_r;
  end

  assign done = done_r;

  // Result record, valid with done.
  always_comb begin
    res              = '0;
    res.pc_after     = pc_r;
    res.mem_written  = wmem_r;
    res.flag_equal   = feq_r;
    res.flag_less    = flt_r;
    res.flag_greater = fgt_r;
    if (!load_r) begin
      res.opcode      = op;
      res.dest_index  = rx;
      res.dest_value  = regs_r[rx];
      res.reg_written = wreg_r;
      res.halt_seen   = (op == scpu_pkg::OP_HLT);
      res.bad_opcode  = (op >= scpu_pkg::OP_BAD);
    end
  end

endmodule

[rtl/core/scpu_checker.sv]
// Port-level checker for the processor core, bound to the top level.
// Depends only on the top level's ports.
module scpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // No new item is taken while a result waits.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("item accepted with result pending");

  // A result never appears in the cycle right after an accept.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result changed");

  // Halt and bad opcode never show together.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[44] && out_tdata[45])) else $error("halt and bad opcode");

endmodule

bind small_cpu_fetch_decode_execute_core scpu_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
